// ----- src/vmts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vmts_pkg
// Types and constants shared by the video mode timing sequencer modules.
// ---------------------------------------------------------------------------
package vmts_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    localparam int DOT_W  = 7;
    localparam int CNT_W  = 10;
    localparam int LINE_W = 8;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 8;

    localparam logic [DOT_W-1:0]  MAX_DOTS    = 7'd80;
    localparam logic [CNT_W-1:0]  DOTS_OAM    = 10'd80;
    localparam logic [CNT_W-1:0]  DOTS_DRAW   = 10'd172;
    localparam logic [CNT_W-1:0]  DOTS_HBLANK = 10'd204;
    localparam logic [CNT_W-1:0]  DOTS_LINE   = 10'd456;
    localparam logic [LINE_W-1:0] LINE_VBLANK = 8'd144;
    localparam logic [LINE_W-1:0] LINE_LAST   = 8'd153;

    localparam logic [IDX_W-1:0] REG_DISPLAY_ON    = 3'd0;
    localparam logic [IDX_W-1:0] REG_COMPARE_LINE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HBLANK_IRQ_EN = 3'd2;
    localparam logic [IDX_W-1:0] REG_VBLANK_STAT_EN = 3'd3;
    localparam logic [IDX_W-1:0] REG_OAM_IRQ_EN    = 3'd4;
    localparam logic [IDX_W-1:0] REG_COMPARE_IRQ_EN = 3'd5;

    typedef struct packed {
        logic              display_on;
        logic [LINE_W-1:0] compare_line;
        logic              hblank_irq_enable;
        logic              vblank_stat_enable;
        logic              oam_irq_enable;
        logic              compare_irq_enable;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [CNT_W-1:0]  dots;
        logic [LINE_W-1:0] line;
        logic              match;
    } t_state;

    // Packed with video_mode in the lowest bits.
    typedef struct packed {
        logic              scan_objects;
        logic              render_line;
        logic              vblank_irq;
        logic              status_irq;
        logic              line_match;
        logic [LINE_W-1:0] line_number;
        t_mode             video_mode;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage
`default_nettype wire

// ----- src/vmts_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vmts_cfg
// Configuration register bank written through the plain write port.
// ---------------------------------------------------------------------------
module vmts_cfg import vmts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DISPLAY_ON:     n_cfg.display_on         = i_cfg_data[0];
                REG_COMPARE_LINE:   n_cfg.compare_line       = i_cfg_data[LINE_W-1:0];
                REG_HBLANK_IRQ_EN:  n_cfg.hblank_irq_enable  = i_cfg_data[0];
                REG_VBLANK_STAT_EN: n_cfg.vblank_stat_enable = i_cfg_data[0];
                REG_OAM_IRQ_EN:     n_cfg.oam_irq_enable     = i_cfg_data[0];
                REG_COMPARE_IRQ_EN: n_cfg.compare_irq_enable = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_on         <= 1'b1;
            r_cfg.compare_line       <= '0;
            r_cfg.hblank_irq_enable  <= 1'b0;
            r_cfg.vblank_stat_enable <= 1'b0;
            r_cfg.oam_irq_enable     <= 1'b0;
            r_cfg.compare_irq_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- src/vmts_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vmts_step
// One timing step: add elapsed dots and take at most one mode transition.
// ---------------------------------------------------------------------------
module vmts_step import vmts_pkg::*; (
    input  t_cfg                  i_cfg,
    input  t_state                i_state,
    input  wire logic [DOT_W-1:0] i_dots,
    output t_state                o_state,
    output t_result               o_result
);

    logic [DOT_W-1:0]  dots_clip;
    logic [CNT_W-1:0]  sum;
    logic [LINE_W-1:0] line_inc;
    logic [LINE_W-1:0] line_new;
    logic              cmp_hit;
    logic              stat;
    logic              vbl;
    logic              render;
    logic              scan;
    t_state            nxt;

    assign dots_clip = (i_dots > MAX_DOTS) ? MAX_DOTS : i_dots;
    assign sum       = i_state.dots + CNT_W'(dots_clip);
    assign line_inc  = i_state.line + 8'd1;
    assign line_new  = (i_state.mode == MODE_VBLANK && line_inc > LINE_LAST) ? '0 : line_inc;
    assign cmp_hit   = (line_new == i_cfg.compare_line);

    always_comb begin
        nxt    = i_state;
        stat   = 1'b0;
        vbl    = 1'b0;
        render = 1'b0;
        scan   = 1'b0;
        if (i_cfg.display_on) begin
            nxt.dots = sum;
            unique case (i_state.mode)
                MODE_OAM: begin
                    if (sum >= DOTS_OAM) begin
                        nxt.dots = sum - DOTS_OAM;
                        nxt.mode = MODE_DRAW;
                    end
                end
                MODE_DRAW: begin
                    if (sum >= DOTS_DRAW) begin
                        nxt.dots = sum - DOTS_DRAW;
                        nxt.mode = MODE_HBLANK;
                        render   = 1'b1;
                        stat     = i_cfg.hblank_irq_enable;
                    end
                end
                MODE_HBLANK: begin
                    if (sum >= DOTS_HBLANK) begin
                        nxt.dots  = sum - DOTS_HBLANK;
                        nxt.line  = line_new;
                        nxt.match = cmp_hit;
                        stat      = cmp_hit & i_cfg.compare_irq_enable;
                        if (line_new == LINE_VBLANK) begin
                            nxt.mode = MODE_VBLANK;
                            vbl      = 1'b1;
                            stat     = stat | i_cfg.vblank_stat_enable;
                        end else begin
                            nxt.mode = MODE_OAM;
                            scan     = 1'b1;
                            stat     = stat | i_cfg.oam_irq_enable;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (sum >= DOTS_LINE) begin
                        nxt.dots  = sum - DOTS_LINE;
                        nxt.line  = line_new;
                        nxt.match = cmp_hit;
                        stat      = cmp_hit & i_cfg.compare_irq_enable;
                        if (line_inc > LINE_LAST) begin
                            nxt.mode = MODE_OAM;
                            scan     = 1'b1;
                            stat     = stat | i_cfg.oam_irq_enable;
                        end
                    end
                end
                default: nxt = i_state;
            endcase
        end
    end

    assign o_state               = nxt;
    assign o_result.video_mode   = nxt.mode;
    assign o_result.line_number  = nxt.line;
    assign o_result.line_match   = nxt.match;
    assign o_result.status_irq   = stat;
    assign o_result.vblank_irq   = vbl;
    assign o_result.render_line  = render;
    assign o_result.scan_objects = scan;

endmodule
`default_nettype wire

// ----- src/video_mode_timing_sequencer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// video_mode_timing_sequencer_core
// Scanline timing generator: mode, line counter, compare flag and pulses.
// ---------------------------------------------------------------------------
// Each transfer on the slave side carries an elapsed dot count and yields one
// result through the input and then the result register. One transfer per
// clock is sustained while m_axis_tready is high: dot counter, mode and line
// update combinationally from the input register into the state and result
// registers; a waiting result stalls them. Configuration writes take effect
// on the next clock; make them only while idle (the block does not enforce it).
module video_mode_timing_sequencer_core import vmts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,  // [6:0] dot_cycles
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [1:0] video_mode, [9:2] line_number, [10] line_match, [11] status_irq,
    // [12] vblank_irq, [13] render_line, [14] scan_objects
    output logic [15:0]           m_axis_tdata
);

    t_cfg             cfg;
    t_state           r_state;
    t_state           n_state;
    t_result          step_res;
    t_result          r_res;
    logic             r_in_valid;
    logic [DOT_W-1:0] r_in_dots;
    logic             r_out_valid;
    logic             advance;

    vmts_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    vmts_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_dots   (r_in_dots),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.mode  <= MODE_OAM;
            r_state.dots  <= '0;
            r_state.line  <= '0;
            r_state.match <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_dots <= s_axis_tdata[DOT_W-1:0];
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16-RES_W){1'b0}}, r_res};

endmodule
`default_nettype wire

// ----- src/vmts_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vmts_chk
// Port-level checks on the timing sequencer, bound to the top level.
// ---------------------------------------------------------------------------
module vmts_chk import vmts_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [15:0]      m_axis_tdata
);

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:2] <= LINE_LAST)
        else $error("line number beyond last line");

    a_vblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |->
            (m_axis_tdata[9:2] == LINE_VBLANK && m_axis_tdata[1:0] == MODE_VBLANK))
        else $error("vblank pulse outside vblank entry");

    a_render_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[1:0] == MODE_HBLANK)
        else $error("render pulse without hblank");

    a_scan_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[14]) |->
            (m_axis_tdata[1:0] == MODE_OAM && m_axis_tdata[12] == 1'b0))
        else $error("scan pulse without OAM scan");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result transfer changed");

endmodule

bind video_mode_timing_sequencer_core vmts_chk u_vmts_chk (.*);
`default_nettype wire
